FILE: hw/rtl/gsba_pkg.sv
// shared types, constants and register map for the gated sensor burst average block
// no dependencies; imported by every module of the block
package gsba_pkg;

  // field widths of the transaction payloads
  localparam int SAMPLE_W  = 12;
  localparam int READING_W = 12;
  localparam int PERIOD_W  = 16;
  localparam int SCALE_W   = 16;

  // converter resolution; bits above it in a sample are dropped
  localparam int ADC_BITS = 12;
  localparam logic [SAMPLE_W-1:0] ADC_MASK =
    (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << ADC_BITS) - 1);

  // default burst length is 2**SAMPLE_SHIFT_DEF samples
  localparam int SAMPLE_SHIFT_DEF = 3;

  // scaled reading saturates here
  localparam logic [READING_W-1:0] READING_MAX = {READING_W{1'b1}};

  // request kinds
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // register port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHARGE_PERIOD = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCALE         = 2'd2;

  // register reset values
  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 16'd2000;
  localparam logic [PERIOD_W-1:0] CHARGE_PERIOD_RST = 16'd20;
  localparam logic [SCALE_W-1:0]  SCALE_RST         = 16'd10430;

  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] adc_sample;
  } req_t;

  typedef struct packed {
    logic                 sense_enable;
    logic                 sampling;
    logic                 reading_valid;
    logic [READING_W-1:0] centivolts;
  } rsp_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] sample_period_ms;
    logic [PERIOD_W-1:0] charge_period_ms;
    logic [SCALE_W-1:0]  scale_q16;
  } cfg_t;

endpackage

FILE: hw/rtl/gated_sensor_burst_average.sv
// top level of the gated sensor burst average block
// depends on gsba_pkg, gsba_cfg_regs, gsba_seq
//
// usage
// - req channel (req_valid/req_ready/req): one transaction per event, either a
//   one millisecond tick or an adc conversion result
// - rsp channel (rsp_valid/rsp_ready/rsp): exactly one transaction per request,
//   giving sense_enable, sampling, a one-shot reading_valid flag and the
//   latest reading in centivolts
// - apb-style port sets sample period, charge period and q16 scale; write it
//   only while no request is in flight
// - request path: the accepting edge loads the input register, and rsp_valid rises
//   when the request moves on into the result register
// - throughput: one request per cycle unless the receiver stalls, set by the single
//   update of the phase/timer/burst registers and one 12x16 multiply per transaction
// - reset: sleeping phase, timer zero, reading zero, registers at defaults;
//   req_ready is high in the first cycle after reset
// - receiver stall: the result holds in the result register, one more request
//   waits in the input register, then req_ready drops
module gated_sensor_burst_average #(
  parameter int SAMPLE_SHIFT = gsba_pkg::SAMPLE_SHIFT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  gsba_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output gsba_pkg::rsp_t                  rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gsba_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gsba_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gsba_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import gsba_pkg::*;

  cfg_t cfg;

  // configuration registers
  gsba_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer and datapath
  gsba_seq #(
    .SAMPLE_SHIFT (SAMPLE_SHIFT)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

FILE: hw/rtl/gsba_cfg_regs.sv
// register file behind the apb-style configuration port
// depends on gsba_pkg
module gsba_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gsba_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [gsba_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [gsba_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output gsba_pkg::cfg_t                   cfg
);
  import gsba_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_period_ms <= SAMPLE_PERIOD_RST;
      cfg.charge_period_ms <= CHARGE_PERIOD_RST;
      cfg.scale_q16        <= SCALE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SAMPLE_PERIOD: cfg.sample_period_ms <= pwdata[PERIOD_W-1:0];
        REG_CHARGE_PERIOD: cfg.charge_period_ms <= pwdata[PERIOD_W-1:0];
        REG_SCALE:         cfg.scale_q16        <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_SAMPLE_PERIOD: prdata = APB_DATA_W'(cfg.sample_period_ms);
      REG_CHARGE_PERIOD: prdata = APB_DATA_W'(cfg.charge_period_ms);
      REG_SCALE:         prdata = APB_DATA_W'(cfg.scale_q16);
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/gsba_scale.sv
// q16 gain stage: burst average times scale, round half up, saturate
// depends on gsba_pkg
module gsba_scale (
  input  logic [gsba_pkg::SAMPLE_W-1:0]  avg,
  input  logic [gsba_pkg::SCALE_W-1:0]   scale_q16,
  output logic [gsba_pkg::READING_W-1:0] reading
);
  import gsba_pkg::*;

  localparam int PROD_W = SAMPLE_W + SCALE_W + 1;
  localparam int RND_W  = PROD_W - SCALE_W;

  logic [PROD_W-1:0] prod;
  logic [RND_W-1:0]  rounded;

  // product plus one half lsb of the result
  assign prod    = PROD_W'(avg) * PROD_W'(scale_q16) + PROD_W'(1 << (SCALE_W - 1));
  assign rounded = prod[PROD_W-1:SCALE_W];

  // clamp to the reading range
  always_comb begin
    if (rounded > RND_W'(READING_MAX)) begin
      reading = READING_MAX;
    end else begin
      reading = rounded[READING_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/gsba_seq.sv
// measurement sequencer: input register, phase/timer/burst state, result register
// depends on gsba_pkg and gsba_scale
module gsba_seq #(
  parameter int SAMPLE_SHIFT = gsba_pkg::SAMPLE_SHIFT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  gsba_pkg::cfg_t cfg,
  input  logic           req_valid,
  output logic           req_ready,
  input  gsba_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output gsba_pkg::rsp_t rsp
);
  import gsba_pkg::*;

  localparam int SUM_W = SAMPLE_W + SAMPLE_SHIFT;
  localparam int IDX_W = (SAMPLE_SHIFT > 0) ? SAMPLE_SHIFT : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'((1 << SAMPLE_SHIFT) - 1);

  typedef enum logic [1:0] {
    PH_SLEEP  = 2'd0,
    PH_CHARGE = 2'd1,
    PH_SAMPLE = 2'd2
  } phase_t;

  // input register
  logic req_q_valid;
  req_t req_q;

  // sequencer state
  phase_t               phase, phase_next;
  logic [PERIOD_W-1:0]  wait_timer, wait_timer_next;
  logic [SUM_W-1:0]     sample_sum, sample_sum_next;
  logic [IDX_W-1:0]     sample_index, sample_index_next;
  logic [READING_W-1:0] last_reading, last_reading_next;
  logic                 reading_valid_next;

  logic                 advance;
  logic                 fire;
  logic [SAMPLE_W-1:0]  smp;
  logic [SUM_W-1:0]     sum_acc;
  logic [SAMPLE_W-1:0]  avg;
  logic [READING_W-1:0] scaled;

  // result register frees when empty or taken this cycle
  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !req_q_valid || advance;
  assign fire      = req_q_valid && advance;

  // burst datapath
  assign smp     = req_q.adc_sample & ADC_MASK;
  assign sum_acc = sample_sum + SUM_W'(smp);
  assign avg     = sum_acc[SUM_W-1:SAMPLE_SHIFT];

  gsba_scale u_scale (
    .avg       (avg),
    .scale_q16 (cfg.scale_q16),
    .reading   (scaled)
  );

  // phase, timer, burst and reading update for the registered transaction
  always_comb begin
    phase_next         = phase;
    wait_timer_next    = wait_timer;
    sample_sum_next    = sample_sum;
    sample_index_next  = sample_index;
    last_reading_next  = last_reading;
    reading_valid_next = 1'b0;
    case (phase)
      PH_SAMPLE: begin
        if (req_q.req_type == REQ_SAMPLE) begin
          if (sample_index == IDX_LAST) begin
            phase_next         = PH_SLEEP;
            wait_timer_next    = cfg.sample_period_ms;
            sample_sum_next    = '0;
            sample_index_next  = '0;
            last_reading_next  = scaled;
            reading_valid_next = 1'b1;
          end else begin
            sample_sum_next   = sum_acc;
            sample_index_next = sample_index + IDX_W'(1);
          end
        end
      end
      PH_CHARGE: begin
        if (req_q.req_type == REQ_TICK) begin
          if (wait_timer == '0) begin
            phase_next        = PH_SAMPLE;
            sample_sum_next   = '0;
            sample_index_next = '0;
          end else begin
            wait_timer_next = wait_timer - PERIOD_W'(1);
          end
        end
      end
      default: begin
        if (req_q.req_type == REQ_TICK) begin
          if (wait_timer == '0) begin
            phase_next      = PH_CHARGE;
            wait_timer_next = cfg.charge_period_ms;
          end else begin
            wait_timer_next = wait_timer - PERIOD_W'(1);
          end
        end
      end
    endcase
  end

  // state, input register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid  <= 1'b0;
      rsp_valid    <= 1'b0;
      phase        <= PH_SLEEP;
      wait_timer   <= '0;
      sample_sum   <= '0;
      sample_index <= '0;
      last_reading <= '0;
    end else begin
      if (req_ready) begin
        req_q_valid <= req_valid;
      end
      if (fire) begin
        phase        <= phase_next;
        wait_timer   <= wait_timer_next;
        sample_sum   <= sample_sum_next;
        sample_index <= sample_index_next;
        last_reading <= last_reading_next;
        rsp_valid    <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (req_valid && req_ready) begin
      req_q <= req;
    end
    if (fire) begin
      rsp.sense_enable  <= (phase_next != PH_SLEEP);
      rsp.sampling      <= (phase_next == PH_SAMPLE);
      rsp.reading_valid <= reading_valid_next;
      rsp.centivolts    <= last_reading_next;
    end
  end

endmodule

FILE: hw/rtl/gsba_checker.sv
// port-level checks for the gated sensor burst average block, with its bind
// depends on gsba_pkg and gated_sensor_burst_average
module gsba_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input gsba_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input gsba_pkg::rsp_t rsp
);
  import gsba_pkg::*;

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid && req_ready)
    else $error("result pending or input blocked after reset");

  // a waiting request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while waiting");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // a finished reading puts the circuit back to sleep
  a_reading_sleeps: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.reading_valid |-> !rsp.sense_enable && !rsp.sampling)
    else $error("reading flagged while sense circuit on");

  // sampling is only entered from charging
  a_sample_entry: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready ##1 rsp_valid && rsp.sampling && !$past(rsp.sampling)
    |-> $past(rsp.sense_enable))
    else $error("sampling entered without charge phase");

endmodule

bind gated_sensor_burst_average gsba_checker u_gsba_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

FILE: test/gsba_reading_checker.sv
// status checker for the gated sensor burst average block
// predicts every status transaction from accepted requests and register writes and compares
// it field by field with the block's output; depends on gsba_pkg
`timescale 1ns / 100ps

module gsba_reading_checker #(
  parameter int SAMPLE_SHIFT = gsba_pkg::SAMPLE_SHIFT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_ready,
  input  gsba_pkg::req_t                  req,
  input  logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  gsba_pkg::rsp_t                  rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gsba_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gsba_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [gsba_pkg::APB_DATA_W-1:0] prdata,
  input  logic                            pready,
  output int                              fail_count,
  output int                              outstanding,
  output int                              readings_seen
);
  import gsba_pkg::*;

  localparam int BURST_LEN   = 1 << SAMPLE_SHIFT;
  localparam int MAX_PRINTED = 40;

  typedef enum logic [1:0] {PH_SLEEPING, PH_CHARGING, PH_SAMPLING} phase_e;

  // register shadow
  logic [PERIOD_W-1:0] sample_period;
  logic [PERIOD_W-1:0] charge_period;
  logic [SCALE_W-1:0]  scale;

  // sequencer state
  phase_e               phase;
  logic [PERIOD_W-1:0]  wait_timer;
  int unsigned          burst_sum;
  int unsigned          burst_count;
  logic [READING_W-1:0] last_reading;

  // predicted status transactions, oldest first
  rsp_t status_q[$];
  int   mismatches = 0;
  int   readings = 0;

  assign fail_count    = mismatches;
  assign readings_seen = readings;

  task automatic report_error(string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic logic [SCALE_W-1:0] reg_shadow(logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_SAMPLE_PERIOD: return sample_period;
      REG_CHARGE_PERIOD: return charge_period;
      REG_SCALE:         return scale;
      default:           return '0;
    endcase
  endfunction

  // average times q16 gain, rounded half up, clipped to the reading range
  function automatic logic [READING_W-1:0] to_centivolts(logic [READING_W-1:0] avg);
    logic [31:0] product;
    product = 32'(avg) * 32'(scale) + 32'h8000;
    if ((product >> SCALE_W) > 32'(READING_MAX)) begin
      return READING_MAX;
    end
    return product[SCALE_W +: READING_W];
  endfunction

  // one request through the sequencer, returns the status it leaves behind
  function automatic rsp_t advance_sequencer(req_t item);
    rsp_t                status;
    logic [SAMPLE_W-1:0] value;
    value  = item.adc_sample & ADC_MASK;
    status = '0;
    if (item.req_type == REQ_TICK) begin
      if (phase != PH_SAMPLING) begin
        if (wait_timer != '0) begin
          wait_timer = wait_timer - 1'b1;
        end else if (phase == PH_CHARGING) begin
          phase       = PH_SAMPLING;
          burst_sum   = 0;
          burst_count = 0;
        end else begin
          phase      = PH_CHARGING;
          wait_timer = charge_period;
        end
      end
    end else if (phase == PH_SAMPLING) begin
      burst_sum += value;
      burst_count++;
      if (burst_count >= BURST_LEN) begin
        last_reading = to_centivolts(READING_W'(burst_sum >> SAMPLE_SHIFT));
        phase        = PH_SLEEPING;
        wait_timer   = sample_period;
        burst_sum    = 0;
        burst_count  = 0;
        status.reading_valid = 1'b1;
      end
    end
    status.sense_enable = (phase != PH_SLEEPING);
    status.sampling     = (phase == PH_SAMPLING);
    status.centivolts   = last_reading;
    return status;
  endfunction

  always @(posedge clk) begin
    rsp_t                 want;
    logic [REG_IDX_W-1:0] idx;
    idx = REG_IDX_W'(paddr >> 2);
    if (rst) begin
      sample_period = SAMPLE_PERIOD_RST;
      charge_period = CHARGE_PERIOD_RST;
      scale         = SCALE_RST;
      phase         = PH_SLEEPING;
      wait_timer    = '0;
      burst_sum     = 0;
      burst_count   = 0;
      last_reading  = '0;
      status_q.delete();
    end else begin
      // register port: writes update the shadow, reads are checked against it
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (idx)
            REG_SAMPLE_PERIOD: sample_period = pwdata[PERIOD_W-1:0];
            REG_CHARGE_PERIOD: charge_period = pwdata[PERIOD_W-1:0];
            REG_SCALE:         scale         = pwdata[SCALE_W-1:0];
            default: ;
          endcase
        end else if (prdata[SCALE_W-1:0] !== reg_shadow(idx)) begin
          report_error($sformatf("register %0d read %h expected %h",
                                 idx, prdata[SCALE_W-1:0], reg_shadow(idx)));
        end
      end

      // request transaction
      if (req_valid && req_ready) begin
        status_q.push_back(advance_sequencer(req));
      end

      // status transaction
      if (rsp_valid && rsp_ready) begin
        if (status_q.size() == 0) begin
          report_error($sformatf("status %h with nothing expected", rsp));
        end else begin
          want = status_q.pop_front();
          if (rsp.sense_enable !== want.sense_enable) begin
            report_error($sformatf("sense_enable got %b expected %b",
                                   rsp.sense_enable, want.sense_enable));
          end
          if (rsp.sampling !== want.sampling) begin
            report_error($sformatf("sampling got %b expected %b",
                                   rsp.sampling, want.sampling));
          end
          if (rsp.reading_valid !== want.reading_valid) begin
            report_error($sformatf("reading_valid got %b expected %b",
                                   rsp.reading_valid, want.reading_valid));
          end
          if (rsp.centivolts !== want.centivolts) begin
            report_error($sformatf("centivolts got %0d expected %0d",
                                   rsp.centivolts, want.centivolts));
          end
          if (want.reading_valid) begin
            readings++;
          end
        end
      end
    end
    outstanding <= status_q.size();
  end

endmodule

FILE: test/gated_sensor_burst_average_tb.sv
// testbench top for the gated sensor burst average block
// drives ticks, adc samples and register writes under varying back-pressure, gives the verdict;
// depends on gsba_pkg, gated_sensor_burst_average and gsba_reading_checker
`timescale 1ns / 100ps

module gated_sensor_burst_average_tb;
  import gsba_pkg::*;

  localparam int SAMPLE_SHIFT = SAMPLE_SHIFT_DEF;
  localparam int BURST_LEN    = 1 << SAMPLE_SHIFT;
  localparam int ITEM_TARGET  = 1250;
  localparam int DIRECTED     = 25;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int NOISE_PCT    = 15;
  localparam logic [PERIOD_W-1:0] PERIOD_TOP = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_t                  rsp;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int outstanding;
  int readings_seen;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int requests_sent = 0;
  int counted_items = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  // tb copy of the periods, and the sleep count left behind by the last reading
  int sample_period = SAMPLE_PERIOD_RST;
  int charge_period = CHARGE_PERIOD_RST;
  int wake_ticks = 0;

  gated_sensor_burst_average #(.SAMPLE_SHIFT(SAMPLE_SHIFT)) u_dut (.*);

  gsba_reading_checker #(.SAMPLE_SHIFT(SAMPLE_SHIFT)) u_checker (.*);

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: random back-pressure plus a long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (holds_asked > holds_done) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one request transaction, with random idle cycles ahead of it
  task automatic send_request(logic kind, logic [SAMPLE_W-1:0] value, bit counts);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= req_t'{req_type: kind, adc_sample: value};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    requests_sent++;
    if (counts) begin
      counted_items++;
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // one register access, setup then access cycle
  task automatic reg_access(logic write, logic [REG_IDX_W-1:0] idx, logic [SCALE_W-1:0] value);
    logic [APB_DATA_W-SCALE_W-1:0] junk;
    junk    = (APB_DATA_W - SCALE_W)'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= {junk, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (write) begin
      reg_writes++;
    end
  endtask

  // all three registers written once the block is idle, then read back
  task automatic load_settings(int sp, int cp, int sc);
    wait_drained();
    reg_access(1'b1, REG_SAMPLE_PERIOD, PERIOD_W'(sp));
    reg_access(1'b1, REG_CHARGE_PERIOD, PERIOD_W'(cp));
    reg_access(1'b1, REG_SCALE, SCALE_W'(sc));
    reg_access(1'b0, REG_SAMPLE_PERIOD, '0);
    reg_access(1'b0, REG_CHARGE_PERIOD, '0);
    reg_access(1'b0, REG_SCALE, '0);
    sample_period = sp;
    charge_period = cp;
  endtask

  function automatic int pick_period();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 1;
      2:       return $urandom_range(11, 40);
      default: return $urandom_range(2, 10);
    endcase
  endfunction

  function automatic int pick_scale();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 65535;
      2:       return 1;
      3:       return 32768;
      default: return $urandom_range(65535);
    endcase
  endfunction

  // full measurement cycle: enough ticks to wake and charge, then one burst;
  // stray samples before the burst and stray ticks inside it are ignored by the block
  task automatic run_reading(int noise_pct);
    int                  lead;
    int                  pattern;
    logic [SAMPLE_W-1:0] level;
    lead    = wake_ticks + charge_period + 2;
    pattern = $urandom_range(3);
    level   = SAMPLE_W'($urandom);
    for (int i = 0; i < lead; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        send_request(REQ_SAMPLE, SAMPLE_W'($urandom), 1'b0);
      end
      send_request(REQ_TICK, SAMPLE_W'($urandom), 1'b1);
    end
    for (int i = 0; i < BURST_LEN; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        send_request(REQ_TICK, SAMPLE_W'($urandom), 1'b0);
      end
      case (pattern)
        1:       ;
        2:       level = $urandom_range(1) ? '1 : '0;
        default: level = SAMPLE_W'($urandom);
      endcase
      send_request(REQ_SAMPLE, level, 1'b1);
    end
    wake_ticks = sample_period;
  endtask

  // stimulus and verdict
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values read back
    reg_access(1'b0, REG_SAMPLE_PERIOD, '0);
    reg_access(1'b0, REG_CHARGE_PERIOD, '0);
    reg_access(1'b0, REG_SCALE, '0);

    // zero periods, full gain, samples outside the burst, tick inside it, full-scale reading
    load_settings(0, 0, 65535);
    send_request(REQ_SAMPLE, '1, 1'b1);
    send_request(REQ_TICK, '0, 1'b1);
    send_request(REQ_SAMPLE, '0, 1'b1);
    send_request(REQ_TICK, '1, 1'b1);
    send_request(REQ_TICK, '0, 1'b1);
    repeat (BURST_LEN) send_request(REQ_SAMPLE, '1, 1'b1);

    // half gain on an average of one rounds half up
    load_settings(0, 0, 32768);
    send_request(REQ_TICK, '0, 1'b1);
    send_request(REQ_TICK, '0, 1'b1);
    send_request(REQ_SAMPLE, SAMPLE_W'(BURST_LEN), 1'b1);
    repeat (BURST_LEN - 1) send_request(REQ_SAMPLE, '0, 1'b1);
    wake_ticks = 0;

    // random cycles under three idle profiles, each opened by a long receiver hold
    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          tx_idle_pct = 10;
          rx_idle_pct = 87;
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct = 10;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      holds_asked++;
      while (counted_items < DIRECTED + (stage + 1) * (ITEM_TARGET - DIRECTED) / 3) begin
        if ($urandom_range(99) < 35) begin
          load_settings(pick_period(), pick_period(), pick_scale());
        end
        run_reading(NOISE_PCT);
      end
    end

    // longest sample period: sleep timer loaded with its top value, then a few ticks off it
    load_settings(PERIOD_TOP, 0, pick_scale());
    run_reading(0);
    repeat (4) send_request(REQ_TICK, SAMPLE_W'($urandom), 1'b1);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d request transactions, %0d completed readings, %0d register writes",
             requests_sent, readings_seen, reg_writes);
    $display("periods from zero to full range, gains from zero to full scale, three idle mixes");
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
